### rtl/rfps_pkg.sv
// shared types, constants and register codes for the flight phase sequencer
package rfps_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned TILT_W      = 12;
    localparam int unsigned PADDR_W     = 4;
    localparam int unsigned S_TDATA_W   = 176;
    localparam int unsigned M_TDATA_W   = 48;
    localparam int unsigned RETRACT_W   = 2;

    localparam logic signed [DATA_W-1:0] LAUNCH_ACCEL_RESET   = 32'sd3211264;
    localparam logic signed [DATA_W-1:0] MAIN_DEPLOY_RESET    = 32'sd400000;
    localparam logic        [TILT_W-1:0] TILT_RETRACT_RESET   = 12'd480;
    localparam logic        [TILT_W-1:0] TILT_APOGEE_RESET    = 12'd1440;

    typedef enum logic [1:0] {
        REG_LAUNCH_ACCEL_LIMIT   = 2'd0,
        REG_MAIN_DEPLOY_ALTITUDE = 2'd1,
        REG_TILT_RETRACT_LIMIT   = 2'd2,
        REG_TILT_APOGEE_LIMIT    = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_PRELAUNCH = 3'd0,
        PH_LAUNCH    = 3'd1,
        PH_COAST     = 3'd2,
        PH_APOGEE    = 3'd3,
        PH_DESCENT   = 3'd4
    } phase_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] launch_accel_limit;
        logic signed [DATA_W-1:0] main_deploy_altitude;
        logic        [TILT_W-1:0] tilt_retract_limit;
        logic        [TILT_W-1:0] tilt_apogee_limit;
    } cfg_t;

    typedef struct packed {
        phase_t                   flight_phase;
        logic signed [DATA_W-1:0] last_velocity_average;
        logic        [DATA_W-1:0] last_pressure_average;
        logic                     drogue_latch;
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] accel_vertical;
        logic        [TILT_W-1:0] tilt_angle;
        logic signed [DATA_W-1:0] velocity_now;
        logic signed [DATA_W-1:0] velocity_average;
        logic        [DATA_W-1:0] pressure_average;
        logic signed [DATA_W-1:0] altitude_mm;
    } in_item_t;

    typedef struct packed {
        phase_t                   phase;
        logic [RETRACT_W-1:0]     retract_requests;
        logic                     altitude_message;
        logic signed [DATA_W-1:0] altitude_payload;
        logic                     drogue_fire;
        logic                     launch_event;
        logic                     apogee_event;
    } out_item_t;

endpackage

### rtl/rfps_cfg_regs.sv
// apb-style configuration registers for the flight phase sequencer
module rfps_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfps_pkg::PADDR_W-1:0]  paddr,
    input  logic [rfps_pkg::DATA_W-1:0]   pwdata,
    output logic [rfps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rfps_pkg::cfg_t                cfg
);
    import rfps_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t reg_sel;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_sel)
                REG_LAUNCH_ACCEL_LIMIT:   cfg_next.launch_accel_limit   = pwdata;
                REG_MAIN_DEPLOY_ALTITUDE: cfg_next.main_deploy_altitude = pwdata;
                REG_TILT_RETRACT_LIMIT:   cfg_next.tilt_retract_limit   = pwdata[TILT_W-1:0];
                REG_TILT_APOGEE_LIMIT:    cfg_next.tilt_apogee_limit    = pwdata[TILT_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.launch_accel_limit   <= LAUNCH_ACCEL_RESET;
            cfg_reg.main_deploy_altitude <= MAIN_DEPLOY_RESET;
            cfg_reg.tilt_retract_limit   <= TILT_RETRACT_RESET;
            cfg_reg.tilt_apogee_limit    <= TILT_APOGEE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // tilt limits read back zero-extended
    always_comb begin
        unique case (reg_sel)
            REG_LAUNCH_ACCEL_LIMIT:   prdata = cfg_reg.launch_accel_limit;
            REG_MAIN_DEPLOY_ALTITUDE: prdata = cfg_reg.main_deploy_altitude;
            REG_TILT_RETRACT_LIMIT:   prdata = {{(DATA_W-TILT_W){1'b0}},
                                                cfg_reg.tilt_retract_limit};
            REG_TILT_APOGEE_LIMIT:    prdata = {{(DATA_W-TILT_W){1'b0}},
                                                cfg_reg.tilt_apogee_limit};
            default:                  prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### rtl/rfps_phase_step.sv
// next flight state and result for one tick
module rfps_phase_step (
    input  rfps_pkg::cfg_t     cfg,
    input  rfps_pkg::state_t   state,
    input  rfps_pkg::in_item_t item,
    output rfps_pkg::state_t   state_next,
    output rfps_pkg::out_item_t result
);
    import rfps_pkg::*;

    logic                 tilt_retract;
    logic                 vote_press;
    logic                 vote_tilt;
    logic                 vote_vel;
    logic                 apogee_vote;
    logic [RETRACT_W-1:0] retracts;
    logic                 alt_msg;
    logic                 launch_ev;
    logic                 apogee_ev;

    assign tilt_retract = item.tilt_angle >= cfg.tilt_retract_limit;
    assign vote_press   = item.pressure_average > state.last_pressure_average;
    assign vote_tilt    = item.tilt_angle >= cfg.tilt_apogee_limit;
    assign vote_vel     = item.velocity_now[DATA_W-1];
    // two of three
    assign apogee_vote  = (vote_press & vote_tilt) | (vote_press & vote_vel)
                        | (vote_tilt & vote_vel);

    always_comb begin
        state_next = state;
        retracts   = {{(RETRACT_W-1){1'b0}}, tilt_retract};
        alt_msg    = 1'b0;
        launch_ev  = 1'b0;
        apogee_ev  = 1'b0;
        unique case (state.flight_phase)
            PH_PRELAUNCH: begin
                if (item.accel_vertical >= cfg.launch_accel_limit) begin
                    state_next.flight_phase = PH_LAUNCH;
                    launch_ev               = 1'b1;
                end
            end
            PH_LAUNCH: begin
                alt_msg = 1'b1;
                if (item.velocity_average < state.last_velocity_average) begin
                    state_next.flight_phase = PH_COAST;
                end
                state_next.last_velocity_average = item.velocity_average;
            end
            PH_COAST: begin
                alt_msg = 1'b1;
                if (apogee_vote) begin
                    state_next.flight_phase = PH_APOGEE;
                    apogee_ev               = 1'b1;
                end
                state_next.last_pressure_average = item.pressure_average;
            end
            PH_APOGEE: begin
                // one more on top of the tilt retract: 2 with excess tilt, else 1
                retracts                = {tilt_retract, ~tilt_retract};
                state_next.drogue_latch = 1'b1;
                if (item.altitude_mm <= cfg.main_deploy_altitude) begin
                    state_next.flight_phase = PH_DESCENT;
                end
            end
            default: begin
                // descent holds until reset
            end
        endcase
    end

    always_comb begin
        result.phase            = state_next.flight_phase;
        result.retract_requests = retracts;
        result.altitude_message = alt_msg;
        result.altitude_payload = alt_msg ? item.altitude_mm : '0;
        result.drogue_fire      = state_next.drogue_latch;
        result.launch_event     = launch_ev;
        result.apogee_event     = apogee_ev;
    end

endmodule

### rtl/rocket_flight_phase_sequencer_core.sv
// top level of the rocket flight phase sequencer: stream channels, registers, state
//
//  channel   | direction | content
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | one tick: accel, tilt, velocity, averages, altitude
//  m_axis    | out       | one result per tick: phase, requests, events
//  apb       | in/out    | four limit registers, 4-byte stride
//
// one tick per cycle sustained while m_tready stays high; a tick passes through the input register
// and then the result register, with the phase logic in between
// flight state advances at the cycle a tick moves from input to result register
// aresetn (synchronous, active low) returns to prelaunch and restores limits
// a stalled m_tready holds the result; one more tick still lands in the input register
module rocket_flight_phase_sequencer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input transfer channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // accel_vertical[31:0], tilt_angle[43:32], velocity_now[75:44],
    // velocity_average[107:76], pressure_average[139:108], altitude_mm[171:140]
    input  logic [rfps_pkg::S_TDATA_W-1:0]    s_tdata,
    // result transfer channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // phase[2:0], retract_requests[4:3], altitude_message[5],
    // altitude_payload[37:6], drogue_fire[38], launch_event[39], apogee_event[40]
    output logic [rfps_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rfps_pkg::PADDR_W-1:0]      paddr,
    input  logic [rfps_pkg::DATA_W-1:0]       pwdata,
    output logic [rfps_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import rfps_pkg::*;

    cfg_t      cfg;
    in_item_t  s_item;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    state_t    state_reg;
    state_t    state_step;
    out_item_t step_result;

    logic      s_accept;
    logic      advance;

    rfps_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // unpack the input transfer
    assign s_item.accel_vertical   = s_tdata[31:0];
    assign s_item.tilt_angle       = s_tdata[43:32];
    assign s_item.velocity_now     = s_tdata[75:44];
    assign s_item.velocity_average = s_tdata[107:76];
    assign s_item.pressure_average = s_tdata[139:108];
    assign s_item.altitude_mm      = s_tdata[171:140];

    // a tick moves on when the result slot is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb begin
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    rfps_phase_step u_phase_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_step),
        .result     (step_result)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg                    <= 1'b0;
            out_valid_reg                   <= 1'b0;
            state_reg.flight_phase          <= PH_PRELAUNCH;
            state_reg.last_velocity_average <= '0;
            state_reg.last_pressure_average <= '0;
            state_reg.drogue_latch          <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_step;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0,
                       out_item_reg.apogee_event,
                       out_item_reg.launch_event,
                       out_item_reg.drogue_fire,
                       out_item_reg.altitude_payload,
                       out_item_reg.altitude_message,
                       out_item_reg.retract_requests,
                       out_item_reg.phase};

    // phase never steps backward
    a_phase_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> state_reg.flight_phase >= $past(state_reg.flight_phase))
        else $error("flight phase moved backward");

    // drogue latch, once set, stays set
    a_drogue_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.drogue_latch |=> state_reg.drogue_latch)
        else $error("drogue latch cleared");

    // a launch event result reports the launch phase
    a_launch_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_item_reg.launch_event |-> out_item_reg.phase == PH_LAUNCH)
        else $error("launch event outside launch phase");

    // an apogee event result reports the apogee phase
    a_apogee_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_item_reg.apogee_event |-> out_item_reg.phase == PH_APOGEE)
        else $error("apogee event outside apogee phase");

    // state only advances when a tick is taken into the result register
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(advance) |-> $stable(state_reg))
        else $error("flight state changed without a tick");

endmodule

### dv/rocket_flight_phase_sequencer_core_tb.sv
// testbench for the flight phase sequencer: one guided flight with random content, checked tick by tick
`timescale 1ns / 100ps

module rocket_flight_phase_sequencer_core_tb;
    import rfps_pkg::*;

    localparam longint S_MIN    = -64'sd2147483648;
    localparam longint S_MAX    = 64'sd2147483647;
    localparam longint U_MAX    = 64'sd4294967295;
    localparam longint TILT_MAX = 2880;
    localparam int     IDLE_PCT = 23;

    // predicts one result per tick and holds the results still owed by the block
    class flight_scoreboard;
        logic signed [DATA_W-1:0] launch_limit;
        logic signed [DATA_W-1:0] deploy_alt;
        logic        [TILT_W-1:0] retract_tilt;
        logic        [TILT_W-1:0] apogee_tilt;
        phase_t                   phase;
        logic signed [DATA_W-1:0] last_vavg;
        logic        [DATA_W-1:0] last_pavg;
        logic                     drogue;
        out_item_t                owed_q[$];
        int                       errors;

        function new();
            launch_limit = LAUNCH_ACCEL_RESET;
            deploy_alt   = MAIN_DEPLOY_RESET;
            retract_tilt = TILT_RETRACT_RESET;
            apogee_tilt  = TILT_APOGEE_RESET;
            phase        = PH_PRELAUNCH;
            last_vavg    = '0;
            last_pavg    = '0;
            drogue       = 1'b0;
            errors       = 0;
        endfunction

        function void set_limit(reg_index_t idx, logic [DATA_W-1:0] v);
            case (idx)
                REG_LAUNCH_ACCEL_LIMIT:   launch_limit = v;
                REG_MAIN_DEPLOY_ALTITUDE: deploy_alt   = v;
                REG_TILT_RETRACT_LIMIT:   retract_tilt = v[TILT_W-1:0];
                REG_TILT_APOGEE_LIMIT:    apogee_tilt  = v[TILT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(in_item_t t);
            out_item_t            r;
            logic [RETRACT_W-1:0] retr;
            logic                 alt_msg;
            int                   votes;
            r       = '0;
            retr    = '0;
            alt_msg = 1'b0;
            // tilt retract is counted ahead of the phase action
            if (t.tilt_angle >= retract_tilt)
                retr = retr + 1'b1;
            case (phase)
                PH_PRELAUNCH: begin
                    if ($signed(t.accel_vertical) >= $signed(launch_limit)) begin
                        phase          = PH_LAUNCH;
                        r.launch_event = 1'b1;
                    end
                end
                PH_LAUNCH: begin
                    alt_msg = 1'b1;
                    if ($signed(t.velocity_average) < $signed(last_vavg))
                        phase = PH_COAST;
                    last_vavg = t.velocity_average;
                end
                PH_COAST: begin
                    alt_msg = 1'b1;
                    votes = int'(t.pressure_average > last_pavg)
                          + int'(t.tilt_angle >= apogee_tilt)
                          + int'($signed(t.velocity_now) < 0);
                    if (votes >= 2) begin
                        phase          = PH_APOGEE;
                        r.apogee_event = 1'b1;
                    end
                    last_pavg = t.pressure_average;
                end
                PH_APOGEE: begin
                    retr   = retr + 1'b1;
                    drogue = 1'b1;
                    if ($signed(t.altitude_mm) <= $signed(deploy_alt))
                        phase = PH_DESCENT;
                end
                default: ;
            endcase
            r.phase            = phase;
            r.retract_requests = retr;
            r.altitude_message = alt_msg;
            r.altitude_payload = alt_msg ? t.altitude_mm : '0;
            r.drogue_fire      = drogue;
            owed_q.push_back(r);
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d);
            out_item_t e;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, d);
                return;
            end
            e = owed_q.pop_front();
            check_field("phase", longint'(e.phase), longint'(d[2:0]));
            check_field("retract_requests", longint'(e.retract_requests), longint'(d[4:3]));
            check_field("altitude_message", longint'(e.altitude_message), longint'(d[5]));
            check_field("altitude_payload", longint'($signed(e.altitude_payload)),
                        longint'($signed(d[37:6])));
            check_field("drogue_fire", longint'(e.drogue_fire), longint'(d[38]));
            check_field("launch_event", longint'(e.launch_event), longint'(d[39]));
            check_field("apogee_event", longint'(e.apogee_event), longint'(d[40]));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [DATA_W-1:0]      pwdata   = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    flight_scoreboard sb;
    bit               steady   = 1'b0;  // both sides stop idling while set
    bit               hold_req = 1'b0;  // asks the receiver for one long hold-off

    always #6 aclk = ~aclk;

    rocket_flight_phase_sequencer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // uniform in [lo, hi], with each end point picked on its own now and then
    function automatic longint pick(longint lo, longint hi);
        longint unsigned span;
        longint unsigned rnd;
        if (hi <= lo)
            return lo;
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            default: begin
                span = longint'(hi - lo) + 1;
                rnd  = {$urandom(), $urandom()};
                return lo + longint'(rnd % span);
            end
        endcase
    endfunction

    // builds the next tick from the predicted flight state; the phase moves on
    // only below the ceiling and with the given chance, otherwise the tick is
    // shaped to hold the phase
    function automatic in_item_t make_tick(phase_t ceiling, int adv_pct);
        in_item_t t;
        bit       adv;
        bit [2:0] votes_on;
        longint   lim;
        longint   last;
        longint   hi;
        longint   tl;
        t.accel_vertical   = 32'(pick(S_MIN, S_MAX));
        t.velocity_now     = 32'(pick(S_MIN, S_MAX));
        t.velocity_average = 32'(pick(S_MIN, S_MAX));
        t.pressure_average = 32'(pick(0, U_MAX));
        t.altitude_mm      = 32'(pick(S_MIN, S_MAX));
        t.tilt_angle       = 12'(pick(0, TILT_MAX));
        // lean on the retract threshold itself
        if ($urandom_range(0, 3) == 0) begin
            tl = longint'(sb.retract_tilt) - $urandom_range(0, 1);
            if (tl < 0) tl = 0;
            if (tl > TILT_MAX) tl = TILT_MAX;
            t.tilt_angle = 12'(tl);
        end
        adv = (sb.phase < ceiling) && ($urandom_range(0, 99) < adv_pct);
        case (sb.phase)
            PH_PRELAUNCH: begin
                lim = longint'($signed(sb.launch_limit));
                if (adv)
                    t.accel_vertical = 32'(pick(lim, S_MAX));
                else if (lim > S_MIN)
                    t.accel_vertical = 32'(pick(S_MIN, lim - 1));
            end
            PH_LAUNCH: begin
                last = longint'($signed(sb.last_vavg));
                if (adv && last > S_MIN) begin
                    t.velocity_average = 32'(pick(S_MIN, last - 1));
                end else begin
                    // mostly small climbs so the average does not pin at the top
                    hi = ($urandom_range(0, 3) != 0) ? last + 65536 : S_MAX;
                    if (hi > S_MAX) hi = S_MAX;
                    t.velocity_average = 32'(pick(last, hi));
                end
            end
            PH_COAST: begin
                // pick which apogee votes hold, two or more only when moving on
                do votes_on = 3'($urandom_range(0, 7));
                while (($countones(votes_on) >= 2) != adv);
                last = longint'(sb.last_pavg);
                if (!votes_on[0])
                    t.pressure_average = 32'(pick(0, last));
                else if (last < U_MAX)
                    t.pressure_average = 32'(pick(last + 1, U_MAX));
                lim = longint'(sb.apogee_tilt);
                if (votes_on[1])
                    t.tilt_angle = 12'(pick(lim, TILT_MAX));
                else if (lim > 0)
                    t.tilt_angle = 12'(pick(0, lim - 1));
                t.velocity_now = votes_on[2] ? 32'(pick(S_MIN, -1)) : 32'(pick(0, S_MAX));
            end
            PH_APOGEE: begin
                lim = longint'($signed(sb.deploy_alt));
                if (adv)
                    t.altitude_mm = 32'(pick(S_MIN, lim));
                else if (lim < S_MAX)
                    t.altitude_mm = 32'(pick(lim + 1, S_MAX));
            end
            default: ;
        endcase
        return t;
    endfunction

    // offers one tick, with random gaps, and notes it at its transfer
    task automatic send_tick(in_item_t t);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, t.altitude_mm, t.pressure_average, t.velocity_average,
                     t.velocity_now, t.tilt_angle, t.accel_vertical};
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(t);
    endtask

    task automatic run_flight(int n, phase_t ceiling, int adv_pct);
        repeat (n) send_tick(make_tick(ceiling, adv_pct));
    endtask

    // stops offering and waits for every owed result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // setup cycle then access cycle; psel stays up for a following write
    task automatic apb_write(reg_index_t idx, logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_limit(idx, v);
    endtask

    task automatic set_limits(logic [DATA_W-1:0] launch, logic [DATA_W-1:0] deploy,
                              logic [TILT_W-1:0] retr, logic [TILT_W-1:0] apog);
        apb_write(REG_LAUNCH_ACCEL_LIMIT, launch);
        apb_write(REG_MAIN_DEPLOY_ALTITUDE, deploy);
        apb_write(REG_TILT_RETRACT_LIMIT, {20'b0, retr});
        apb_write(REG_TILT_APOGEE_LIMIT, {20'b0, apog});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // result side: checks each transfer, idles at random, and serves one
    // long hold-off so the block backs up into its input
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        in_item_t t;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // field extremes and retract boundaries at the reset limits, all in prelaunch
        t = '{accel_vertical: 32'h8000_0000, tilt_angle: 12'd0,
              velocity_now: 32'h8000_0000, velocity_average: 32'h8000_0000,
              pressure_average: 32'h0, altitude_mm: 32'h8000_0000};
        send_tick(t);
        t = '{accel_vertical: 32'd3211263, tilt_angle: 12'd479,
              velocity_now: 32'h7FFF_FFFF, velocity_average: 32'h7FFF_FFFF,
              pressure_average: 32'hFFFF_FFFF, altitude_mm: 32'h7FFF_FFFF};
        send_tick(t);
        t = '{accel_vertical: 32'h0, tilt_angle: 12'd480,
              velocity_now: 32'h0, velocity_average: 32'h0,
              pressure_average: 32'h0, altitude_mm: 32'h0};
        send_tick(t);
        t = '{accel_vertical: 32'hFFFF_FFFF, tilt_angle: 12'd2880,
              velocity_now: 32'hFFFF_FFFF, velocity_average: 32'hFFFF_FFFF,
              pressure_average: 32'h8000_0000, altitude_mm: 32'hFFFF_FFFF};
        send_tick(t);
        run_flight(8, PH_PRELAUNCH, 0);
        drain();

        // long prelaunch with launch out of reach, retract on every tick
        set_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd0, 12'd2880);
        run_flight(200, PH_PRELAUNCH, 0);
        drain();

        // launch, then a climbing velocity average; receiver holds off meanwhile
        set_limits($urandom(), $urandom(), 12'($urandom_range(0, 2880)),
                   12'($urandom_range(0, 2880)));
        hold_req = 1'b1;
        run_flight(150, PH_LAUNCH, 5);
        drain();

        // burnout and coast with at most one apogee vote per tick, no idling on either side
        steady = 1'b1;
        set_limits(32'h8000_0000, $urandom(), 12'($urandom_range(0, 2880)), 12'd2880);
        run_flight(150, PH_COAST, 5);
        drain();
        steady = 1'b0;

        // apogee with tilt always voting, deploy altitude at the bottom
        set_limits($urandom(), 32'h8000_0000, 12'($urandom_range(0, 2880)), 12'd0);
        run_flight(150, PH_APOGEE, 5);
        drain();

        // apogee hold with retract every tick, then descent
        set_limits($urandom(), $urandom(), 12'd0, 12'($urandom_range(0, 2880)));
        run_flight(100, PH_DESCENT, 5);
        drain();

        set_limits($urandom(), $urandom(), 12'd2880, 12'($urandom_range(0, 2880)));
        run_flight(130, PH_DESCENT, 100);
        drain();

        // leave room for anything stray
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
